// ----- design/odst_pkg.sv -----
package odst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ENTRY_W      = 9;
    localparam int COUNT_OUT_W  = 7;
    localparam int INDEX_W      = 6;

    // Month lengths, no leap years
    localparam logic [4:0] LEN_LONG  = 5'd31;
    localparam logic [4:0] LEN_SHORT = 5'd30;
    localparam logic [4:0] LEN_FEB   = 5'd28;

    localparam logic [3:0] M_JAN = 4'd1;
    localparam logic [3:0] M_FEB = 4'd2;
    localparam logic [3:0] M_MAR = 4'd3;
    localparam logic [3:0] M_APR = 4'd4;
    localparam logic [3:0] M_MAY = 4'd5;
    localparam logic [3:0] M_JUN = 4'd6;
    localparam logic [3:0] M_JUL = 4'd7;
    localparam logic [3:0] M_AUG = 4'd8;
    localparam logic [3:0] M_SEP = 4'd9;
    localparam logic [3:0] M_OCT = 4'd10;
    localparam logic [3:0] M_NOV = 4'd11;
    localparam logic [3:0] M_DEC = 4'd12;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_DEL     = 3'd1,
        OP_DEL_IDX = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_HAS     = 3'd4,
        OP_READ    = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_FULL      = 3'd4,
        ST_BAD_DATE  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FETCH,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                  status;
        logic                     found;
        logic [COUNT_OUT_W-1:0]   count;
        logic [3:0]               read_month;
        logic [4:0]               read_day;
    } t_result;

    function automatic logic [4:0] f_month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: len = LEN_LONG;
            M_APR, M_JUN, M_SEP, M_NOV:                       len = LEN_SHORT;
            M_FEB:                                            len = LEN_FEB;
            default:                                          len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic f_date_ok(input logic [3:0] m, input logic [4:0] d);
        logic [4:0] lim;
        lim = f_month_len(m);
        return (lim != 5'd0) && (d != 5'd0) && (d <= lim);
    endfunction

endpackage

// ----- design/odst_if.sv -----
interface odst_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [3:0] month;
    logic [4:0] day;
    logic [5:0] index;

    modport source (output valid, output op, output month, output day, output index,
                    input ready);
    modport sink   (input valid, input op, input month, input day, input index,
                    output ready);
endinterface

interface odst_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       found;
    logic [6:0] count;
    logic [3:0] read_month;
    logic [4:0] read_day;

    modport source (output valid, output status, output found, output count,
                    output read_month, output read_day, input ready);
    modport sink   (input valid, input status, input found, input count,
                    input read_month, input read_day, output ready);
endinterface

// ----- design/odst_mem.sv -----
module odst_mem #(
    parameter int DEPTH = odst_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(odst_pkg::CAPACITY_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [odst_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [odst_pkg::ENTRY_W-1:0] o_rdata
);
    import odst_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/odst_seq.sv -----
module odst_seq #(
    parameter int CAPACITY = odst_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(odst_pkg::CAPACITY_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_op,
    input  logic [3:0]                   i_month,
    input  logic [4:0]                   i_day,
    input  logic [5:0]                   i_index,
    output logic                         o_done,
    input  logic                         i_take,
    output odst_pkg::t_result            o_result,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic [odst_pkg::ENTRY_W-1:0] o_mem_wdata,
    output logic [AW-1:0]                o_mem_raddr,
    input  logic [odst_pkg::ENTRY_W-1:0] i_mem_rdata
);
    import odst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    t_state               r_state, n_state;
    logic [2:0]           r_op, n_op;
    logic [ENTRY_W-1:0]   r_key, n_key;
    logic [INDEX_W-1:0]   r_idx, n_idx;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_wptr, n_wptr;
    logic                 r_pend, n_pend;
    logic [CW-1:0]        r_count, n_count;
    t_status              r_status, n_status;
    logic                 r_found, n_found;
    logic [ENTRY_W-1:0]   r_rd_key, n_rd_key;

    logic                 w_acc;
    logic                 w_in_ok;
    logic                 w_idx_bad;
    logic                 w_hit;
    logic                 w_more;
    logic                 w_full;
    logic [CW-1:0]        w_ptr_m1;
    logic [XW-1:0]        w_count_x;

    assign w_acc     = i_valid && (r_state == S_IDLE);
    assign w_in_ok   = f_date_ok(i_month, i_day);
    assign w_idx_bad = IW'(i_index) >= IW'(r_count);
    // the one shared comparator: stored entry against the request key
    assign w_hit     = r_pend && (i_mem_rdata == r_key);
    assign w_more    = r_ptr < r_count;
    assign w_full    = r_count == CW'(CAPACITY);
    assign w_ptr_m1  = r_ptr - CW'(1);
    assign w_count_x = XW'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_op)
                        OP_ADD, OP_DEL, OP_HAS: n_state = w_in_ok ? S_SCAN : S_DONE;
                        OP_DEL_IDX:             n_state = w_idx_bad ? S_DONE : S_SHIFT;
                        OP_READ:                n_state = w_idx_bad ? S_DONE : S_FETCH;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_op == OP_DEL) ? S_SHIFT : S_DONE;
                end else if (!w_more) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!w_more && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_FETCH: n_state = S_READ;
            S_READ:  n_state = S_DONE;
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        n_op     = r_op;
        n_key    = r_key;
        n_idx    = r_idx;
        n_ptr    = r_ptr;
        n_wptr   = r_wptr;
        n_pend   = 1'b0;
        n_count  = r_count;
        n_status = r_status;
        n_found  = r_found;
        n_rd_key = r_rd_key;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op     = i_op;
                    n_key    = {i_month, i_day};
                    n_idx    = i_index;
                    n_ptr    = '0;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_rd_key = '0;
                    case (i_op)
                        OP_ADD, OP_DEL, OP_HAS: begin
                            if (!w_in_ok) begin
                                n_status = ST_BAD_DATE;
                            end
                        end
                        OP_DEL_IDX: begin
                            if (w_idx_bad) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_wptr = AW'(i_index);
                                n_ptr  = CW'(i_index) + CW'(1);
                            end
                        end
                        OP_CLEAR: n_count = '0;
                        OP_READ: begin
                            if (w_idx_bad) begin
                                n_status = ST_BAD_INDEX;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    case (r_op)
                        OP_ADD:  n_status = ST_PRESENT;
                        OP_DEL:  n_wptr   = w_ptr_m1[AW-1:0];
                        default: ;
                    endcase
                end else if (w_more) begin
                    n_ptr  = r_ptr + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    case (r_op)
                        OP_ADD: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DEL:  n_status = ST_NOT_FOUND;
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    n_wptr = r_wptr + AW'(1);
                end
                if (w_more) begin
                    n_ptr  = r_ptr + CW'(1);
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                end
            end
            S_READ:  n_rd_key = i_mem_rdata;
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_done      = (r_state == S_DONE);
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wptr;
        o_mem_wdata = r_key;
        o_mem_raddr = r_ptr[AW-1:0];
        case (r_state)
            S_SCAN: begin
                if (!w_hit && !w_more && (r_op == OP_ADD) && !w_full) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_count[AW-1:0];
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata;
                end
            end
            S_FETCH: o_mem_raddr = AW'(r_idx);
            default: ;
        endcase
        o_result.status     = r_status;
        o_result.found      = r_found;
        o_result.count      = w_count_x[COUNT_OUT_W-1:0];
        o_result.read_month = r_rd_key[8:5];
        o_result.read_day   = r_rd_key[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_wptr   <= n_wptr;
        r_status <= n_status;
        r_found  <= n_found;
        r_rd_key <= n_rd_key;
    end

endmodule

// ----- design/ordered_date_set_table_unit.sv -----
// Channel  Dir  Fields                                        Accepted when
// i_req    in   op, month, day, index                         valid && ready
// o_rsp    out  status, found, count, read_month, read_day    valid && ready
//
// One request at a time; i_req.ready is high only while the sequencer idles.
// Add, remove by value and membership test walk the table one entry per
// cycle through a single key comparator. Both removes then shift each
// later entry down (one memory read and one write per cycle); read passes
// through fetch and read states, clear and rejects go straight to done.
// Reset clears the sequencer and the entry count; table contents are not
// cleared. A finished result waits in the output register while the next
// request is taken; the sequencer holds its result until the register can load.
module ordered_date_set_table_unit #(
    parameter int CAPACITY = odst_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    odst_req_if.sink          i_req,
    odst_rsp_if.source        o_rsp
);
    import odst_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                 w_ready;
    logic                 w_done;
    logic                 w_take;
    t_result              w_result;
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_waddr;
    logic [ENTRY_W-1:0]   w_mem_wdata;
    logic [AW-1:0]        w_mem_raddr;
    logic [ENTRY_W-1:0]   w_mem_rdata;
    logic                 w_acc;

    logic                 r_out_valid;
    t_result              r_out;

    // sequencer: FSM plus the shared compare and pointer logic
    odst_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (w_ready),
        .i_op        (i_req.op),
        .i_month     (i_req.month),
        .i_day       (i_req.day),
        .i_index     (i_req.index),
        .o_done      (w_done),
        .i_take      (w_take),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // date table, one write and one registered read per cycle
    odst_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign i_req.ready = w_ready;
    assign w_acc       = i_req.valid && w_ready;

    // output register frees the sequencer as soon as it can load
    assign w_take = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_done) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.found      = r_out.found;
    assign o_rsp.count      = r_out.count;
    assign o_rsp.read_month = r_out.read_month;
    assign o_rsp.read_day   = r_out.read_day;

    // not ready in the cycle after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !w_ready)
        else $error("request taken while previous one in flight");

    // a rejected date never reports membership
    a_bad_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && (w_result.status == ST_BAD_DATE)) |-> !w_result.found)
        else $error("found set on invalid date");

    // read fields carry data only on success
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && (w_result.status != ST_OK)) |->
            ((w_result.read_month == 4'd0) && (w_result.read_day == 5'd0)))
        else $error("read data on failed request");

    // output register loads only from a finished sequencer result
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !w_done) |=> !r_out_valid)
        else $error("response valid without a finished request");

endmodule

// ----- tb/tb_ordered_date_set_table_unit.sv -----
`timescale 1ns / 100ps

module tb_ordered_date_set_table_unit;
    import odst_pkg::*;

    localparam int DEPTH         = CAPACITY_DEF;
    localparam int HALF_PERIOD   = 4;
    localparam int RANDOM_ITEMS  = 1575;
    localparam int EPISODE_LEN   = 120;
    localparam int SETTLE_CYCLES = 4 * DEPTH + 40;
    localparam int LIMIT_NS      = 15_000_000;

    // Op codes the block does not decode; they must leave the table alone
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // Flavor of a stretch of random requests
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_BLEND,
        MIX_DRAIN
    } t_mix;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] month;
        logic [4:0] day;
        logic [5:0] index;
    } t_date_req;

    typedef struct packed {
        t_date_req req;
        logic      typed;
        t_result   want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    odst_req_if req_ch ();
    odst_rsp_if rsp_ch ();

    ordered_date_set_table_unit #(
        .CAPACITY (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Shadow copy of the date table, updated as each request is taken
    logic [8:0] shadow_dates [DEPTH];
    int         shadow_count;

    t_result    pending_results [$];
    t_plan_row  directed_rows [$];
    int         mismatch_count = 0;
    logic       no_gaps;

    function automatic int days_in(input logic [3:0] m);
        case (m)
            M_FEB:                                           return LEN_FEB;
            M_APR, M_JUN, M_SEP, M_NOV:                      return LEN_SHORT;
            M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: return LEN_LONG;
            default:                                         return 0;
        endcase
    endfunction

    // Removes the entry at pos and closes the gap, keeping insertion order
    function automatic void shadow_drop(input int pos);
        for (int i = pos + 1; i < shadow_count; i++) begin
            shadow_dates[i - 1] = shadow_dates[i];
        end
        shadow_count--;
    endfunction

    // Applies one request to the shadow table and returns the response it must get
    function automatic t_result date_table_step(input t_date_req r);
        t_result    res;
        logic [8:0] key;
        int         lim;
        int         pos;
        res = '0;
        key = {r.month, r.day};
        lim = days_in(r.month);
        pos = -1;
        case (r.op)
            OP_ADD, OP_DEL, OP_HAS: begin
                if (lim == 0 || r.day == 5'd0 || int'(r.day) > lim) begin
                    res.status = ST_BAD_DATE;
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (pos < 0 && shadow_dates[i] == key) pos = i;
                    end
                    res.found = (pos >= 0);
                    if (r.op == OP_ADD) begin
                        if (pos >= 0) begin
                            res.status = ST_PRESENT;
                        end else if (shadow_count >= DEPTH) begin
                            res.status = ST_FULL;
                        end else begin
                            shadow_dates[shadow_count] = key;
                            shadow_count++;
                        end
                    end else if (r.op == OP_DEL) begin
                        if (pos < 0) res.status = ST_NOT_FOUND;
                        else         shadow_drop(pos);
                    end
                end
            end
            OP_DEL_IDX: begin
                if (int'(r.index) >= shadow_count || int'(r.index) >= DEPTH) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    shadow_drop(int'(r.index));
                end
            end
            // Entries keep their bits, they just stop counting
            OP_CLEAR: shadow_count = 0;
            OP_READ: begin
                if (int'(r.index) >= shadow_count || int'(r.index) >= DEPTH) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    res.read_month = shadow_dates[r.index][8:5];
                    res.read_day   = shadow_dates[r.index][4:0];
                end
            end
            default: ;
        endcase
        res.count = COUNT_OUT_W'(shadow_count);
        return res;
    endfunction

    function automatic void plan_request(input logic [2:0] op, input logic [3:0] m,
                                         input logic [4:0] d, input logic [5:0] idx,
                                         input logic typed, input t_status st,
                                         input logic f, input logic [6:0] cnt,
                                         input logic [3:0] rm, input logic [4:0] rd);
        t_plan_row row;
        row.req   = {op, m, d, idx};
        row.typed = typed;
        row.want  = '0;
        row.want.status     = st;
        row.want.found      = f;
        row.want.count      = cnt;
        row.want.read_month = rm;
        row.want.read_day   = rd;
        directed_rows.push_back(row);
    endfunction

    function automatic t_date_req pick_request(input t_mix mix);
        t_date_req r;
        int        roll;
        int        w_add, w_del, w_didx, w_has, w_read, w_clr, w_present;
        case (mix)
            MIX_GROW: begin
                w_add = 85; w_del = 3; w_didx = 3; w_has = 4; w_read = 5; w_clr = 0;
                w_present = 10;
            end
            MIX_DRAIN: begin
                w_add = 10; w_del = 35; w_didx = 30; w_has = 10; w_read = 12; w_clr = 3;
                w_present = 45;
            end
            default: begin
                w_add = 30; w_del = 15; w_didx = 12; w_has = 15; w_read = 20; w_clr = 4;
                w_present = 40;
            end
        endcase

        roll = $urandom_range(0, 99);
        if (roll < w_add)                                 r.op = OP_ADD;
        else if (roll < w_add + w_del)                    r.op = OP_DEL;
        else if (roll < w_add + w_del + w_didx)           r.op = OP_DEL_IDX;
        else if (roll < w_add + w_del + w_didx + w_has)   r.op = OP_HAS;
        else if (roll < 100 - w_clr - (mix == MIX_BLEND ? 4 : 0)) r.op = OP_READ;
        else if (roll < 100 - (mix == MIX_BLEND ? 4 : 0)) r.op = OP_CLEAR;
        else r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;

        // Date operand: raw bits, a date already stored, or a fresh legal date
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            r.month = 4'($urandom_range(0, 15));
            r.day   = 5'($urandom_range(0, 31));
        end else if (roll < 10 + w_present && shadow_count > 0) begin
            {r.month, r.day} = shadow_dates[$urandom_range(0, shadow_count - 1)];
        end else begin
            r.month = 4'($urandom_range(1, 12));
            r.day   = 5'($urandom_range(1, days_in(r.month)));
        end

        // Index: mostly in range, sometimes right at the end, sometimes anywhere
        roll = $urandom_range(0, 99);
        if (roll < 75 && shadow_count > 0) r.index = 6'($urandom_range(0, shadow_count - 1));
        else if (roll < 85)                r.index = 6'(shadow_count);
        else                               r.index = 6'($urandom_range(0, 63));
        return r;
    endfunction

    // Drives one request, waits for it to be taken, then books its response
    task automatic send_request(input t_date_req r, input logic typed, input t_result want);
        t_result model;
        while (!no_gaps && $urandom_range(0, 99) < 25) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= r.op;
        req_ch.month <= r.month;
        req_ch.day   <= r.day;
        req_ch.index <= r.index;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        model = date_table_step(r);
        pending_results.push_back(typed ? want : model);
    endtask

    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Response side: random back-pressure outside the quiet stretch
    always @(posedge i_clk) begin
        rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding, status %0d", rsp_ch.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",     want.status,     rsp_ch.status);
                check_field("found",      want.found,      rsp_ch.found);
                check_field("count",      want.count,      rsp_ch.count);
                check_field("read_month", want.read_month, rsp_ch.read_month);
                check_field("read_day",   want.read_day,   rsp_ch.read_day);
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_mix mix;
        shadow_count   = 0;
        no_gaps        = 1'b0;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_ADD;
        req_ch.month   = '0;
        req_ch.day     = '0;
        req_ch.index   = '0;
        for (int i = 0; i < DEPTH; i++) shadow_dates[i] = '0;

        // Empty table: index ops miss, lookups of a legal date come back empty
        plan_request(OP_READ,    4'd0,  5'd0,  6'd0,  1, ST_BAD_INDEX, 0, 0, 0, 0);
        plan_request(OP_DEL_IDX, 4'd0,  5'd0,  6'd0,  1, ST_BAD_INDEX, 0, 0, 0, 0);
        plan_request(OP_HAS,     M_JAN, 5'd1,  6'd0,  1, ST_OK,        0, 0, 0, 0);
        plan_request(OP_DEL,     M_JAN, 5'd1,  6'd0,  1, ST_NOT_FOUND, 0, 0, 0, 0);
        // Bad dates: month zero, above December, all ones, Feb 29, Apr 31, day zero
        plan_request(OP_ADD,     4'd0,  5'd1,  6'd0,  1, ST_BAD_DATE,  0, 0, 0, 0);
        plan_request(OP_ADD,     4'd13, 5'd1,  6'd0,  1, ST_BAD_DATE,  0, 0, 0, 0);
        plan_request(OP_ADD,     4'd15, 5'd31, 6'd63, 1, ST_BAD_DATE,  0, 0, 0, 0);
        plan_request(OP_ADD,     M_FEB, 5'd29, 6'd0,  1, ST_BAD_DATE,  0, 0, 0, 0);
        plan_request(OP_ADD,     M_APR, 5'd31, 6'd0,  1, ST_BAD_DATE,  0, 0, 0, 0);
        plan_request(OP_ADD,     M_JAN, 5'd0,  6'd0,  1, ST_BAD_DATE,  0, 0, 0, 0);
        // First and last day of the year, last day of February, then a duplicate
        plan_request(OP_ADD,     M_JAN, 5'd1,  6'd0,  1, ST_OK,        0, 1, 0, 0);
        plan_request(OP_ADD,     M_DEC, 5'd31, 6'd0,  1, ST_OK,        0, 2, 0, 0);
        plan_request(OP_ADD,     M_FEB, 5'd28, 6'd0,  1, ST_OK,        0, 3, 0, 0);
        plan_request(OP_ADD,     M_JAN, 5'd1,  6'd0,  1, ST_PRESENT,   1, 3, 0, 0);
        plan_request(OP_HAS,     M_DEC, 5'd31, 6'd0,  1, ST_OK,        1, 3, 0, 0);
        plan_request(OP_READ,    4'd0,  5'd0,  6'd1,  1, ST_OK,        0, 3, 12, 31);
        plan_request(OP_READ,    4'd0,  5'd0,  6'd63, 1, ST_BAD_INDEX, 0, 3, 0, 0);
        plan_request(OP_DEL,     M_DEC, 5'd31, 6'd0,  1, ST_OK,        1, 2, 0, 0);
        // After the shift, index 1 holds what was index 2
        plan_request(OP_READ,    4'd0,  5'd0,  6'd1,  0, ST_OK,        0, 0, 0, 0);
        plan_request(OP_DEL_IDX, 4'd0,  5'd0,  6'd0,  0, ST_OK,        0, 0, 0, 0);
        plan_request(OP_SPARE_A, 4'd15, 5'd31, 6'd63, 0, ST_OK,        0, 0, 0, 0);
        plan_request(OP_SPARE_B, 4'd0,  5'd0,  6'd0,  0, ST_OK,        0, 0, 0, 0);
        plan_request(OP_HAS,     4'd13, 5'd0,  6'd0,  1, ST_BAD_DATE,  0, 1, 0, 0);
        plan_request(OP_CLEAR,   4'd0,  5'd0,  6'd0,  1, ST_OK,        0, 0, 0, 0);
        plan_request(OP_READ,    4'd0,  5'd0,  6'd0,  1, ST_BAD_INDEX, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random part: grow to full, churn, drain, churn, and again
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / EPISODE_LEN) % 4)
                0:       mix = MIX_GROW;
                2:       mix = MIX_DRAIN;
                default: mix = MIX_BLEND;
            endcase
            no_gaps <= (n >= 400 && n < 700);
            send_request(pick_request(mix), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/odst_pkg.sv
design/odst_if.sv
design/odst_mem.sv
design/odst_seq.sv
design/ordered_date_set_table_unit.sv
tb/tb_ordered_date_set_table_unit.sv
